/* design/rtd_pkg.sv */
`timescale 1ns / 1ps
// types, constants and helper functions for the run-length text decoder
// no dependencies; used by rtd_step, rtd_out_fifo and rle_text_run_decoder
package rtd_pkg;

    // grid limits
    localparam int          MAX_CELLS       = 16384;
    localparam logic [14:0] GRID_MAX        = 15'(MAX_CELLS);
    localparam logic [14:0] TOTAL_RESET     = 15'd10000;

    // accumulator saturation points
    localparam logic [14:0] COUNT_SAT       = 15'd32767;
    localparam logic [8:0]  VALUE_SAT       = 9'd511;
    localparam logic [8:0]  VALUE_MAX       = 9'd255;

    // character codes
    localparam logic [7:0]  CH_ZERO         = 8'h30;
    localparam logic [7:0]  CH_NINE         = 8'h39;
    localparam logic [7:0]  CH_COLON        = 8'h3A;
    localparam logic [7:0]  CH_SPACE        = 8'h20;
    localparam logic [7:0]  CH_TAB          = 8'h09;
    localparam logic [7:0]  CH_CR           = 8'h0D;

    // result queue
    localparam int          FIFO_DEPTH      = 4;
    localparam int          FIFO_AW         = $clog2(FIFO_DEPTH);
    localparam int          FIFO_CW         = $clog2(FIFO_DEPTH + 1);

    // output word kinds
    localparam logic        KIND_RUN        = 1'b0;
    localparam logic        KIND_DONE       = 1'b1;

    typedef enum logic [2:0] {
        PH_BETWEEN = 3'd0,
        PH_COUNT   = 3'd1,
        PH_COLON   = 3'd2,
        PH_VALUE   = 3'd3
    } t_phase;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_BAD_START = 3'd1,
        ERR_NO_COLON  = 3'd2,
        ERR_NO_VALUE  = 3'd3,
        ERR_OVERFLOW  = 3'd4,
        ERR_SHORT     = 3'd5,
        ERR_TRAILING  = 3'd6,
        ERR_BIG_VALUE = 3'd7
    } t_err;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_final;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic [13:0] start_index;
        logic [14:0] run_length;
        logic [7:0]  cell_value;
        logic [2:0]  error_code;
        logic        is_last;
    } t_out_word;

    // parse state; placed_hi marks a cell count that has passed 15 bits
    typedef struct packed {
        t_phase      phase;
        logic [14:0] count_acc;
        logic [8:0]  value_acc;
        logic [14:0] cells_placed;
        logic        placed_hi;
        t_err        sticky_error;
    } t_parse_state;

    // acc * 10 + digit, saturating at the count limit
    function automatic logic [14:0] sat_count(input logic [14:0] acc, input logic [3:0] d);
        logic [18:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {15'd0, d};
        return (v > {4'd0, COUNT_SAT}) ? COUNT_SAT : v[14:0];
    endfunction

    // acc * 10 + digit, saturating at the value limit
    function automatic logic [8:0] sat_value(input logic [8:0] acc, input logic [3:0] d);
        logic [12:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {9'd0, d};
        return (v > {4'd0, VALUE_SAT}) ? VALUE_SAT : v[8:0];
    endfunction

endpackage

/* design/rtd_step.sv */
`timescale 1ns / 1ps
// one-character parse step: next parse state plus run and done words
// depends on rtd_pkg
module rtd_step (
    input  rtd_pkg::t_parse_state i_state,
    input  rtd_pkg::t_in_word     i_word,
    input  logic [14:0]           i_total_cells,
    output rtd_pkg::t_parse_state o_state,
    output logic                  o_run_valid,
    output rtd_pkg::t_out_word    o_run_word,
    output logic                  o_done_valid,
    output rtd_pkg::t_out_word    o_done_word
);

    logic [14:0] total;
    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic        in_value;
    logic        in_count;
    logic        in_colon;
    logic [8:0]  val1;
    logic [15:0] sum_placed;
    logic        le_total;
    logic        fin_big;
    logic        fin_over;
    logic        ge_total;

    // grid size is the register clamped to the maximum
    assign total = (i_total_cells > rtd_pkg::GRID_MAX) ? rtd_pkg::GRID_MAX : i_total_cells;

    // character classes
    assign is_digit = (i_word.ch >= rtd_pkg::CH_ZERO) && (i_word.ch <= rtd_pkg::CH_NINE);
    assign is_space = (i_word.ch == rtd_pkg::CH_SPACE) ||
                      ((i_word.ch >= rtd_pkg::CH_TAB) && (i_word.ch <= rtd_pkg::CH_CR));
    assign digit    = 4'(i_word.ch - rtd_pkg::CH_ZERO);

    // phase decode; unused codes behave as between pairs
    always_comb begin
        in_value = 1'b0;
        in_count = 1'b0;
        in_colon = 1'b0;
        unique case (i_state.phase)
            rtd_pkg::PH_VALUE: in_value = 1'b1;
            rtd_pkg::PH_COUNT: in_count = 1'b1;
            rtd_pkg::PH_COLON: in_colon = 1'b1;
            default: ;
        endcase
    end

    // value after this character, as seen by a pair that closes now
    always_comb begin
        val1 = i_state.value_acc;
        if (in_value && is_digit) begin
            val1 = rtd_pkg::sat_value(i_state.value_acc, digit);
        end else if (in_colon && is_digit) begin
            val1 = {5'd0, digit};
        end
    end

    // pair completion checks
    assign sum_placed = {1'b0, i_state.count_acc} + {1'b0, i_state.cells_placed};
    assign le_total   = !i_state.placed_hi && (i_state.cells_placed <= total);
    assign fin_big    = val1 > rtd_pkg::VALUE_MAX;
    assign fin_over   = le_total && (sum_placed > {1'b0, total});

    // parse step and end-of-text handling
    always_comb begin
        o_state      = i_state;
        o_run_valid  = 1'b0;
        o_done_valid = 1'b0;
        ge_total     = 1'b0;

        o_run_word             = '0;
        o_run_word.kind        = rtd_pkg::KIND_RUN;
        o_run_word.start_index = i_state.cells_placed[13:0];
        o_run_word.run_length  = i_state.count_acc;
        o_run_word.cell_value  = val1[7:0];

        o_done_word         = '0;
        o_done_word.kind    = rtd_pkg::KIND_DONE;
        o_done_word.is_last = 1'b1;

        if (i_state.sticky_error == rtd_pkg::ERR_OK) begin
            if (in_value && is_digit) begin
                o_state.value_acc = val1;
            end else if (in_count) begin
                if (is_digit) begin
                    o_state.count_acc = rtd_pkg::sat_count(i_state.count_acc, digit);
                end else if (i_word.ch == rtd_pkg::CH_COLON) begin
                    o_state.phase = rtd_pkg::PH_COLON;
                end else begin
                    o_state.sticky_error = rtd_pkg::ERR_NO_COLON;
                end
            end else if (in_colon) begin
                if (is_digit) begin
                    o_state.value_acc = val1;
                    o_state.phase     = rtd_pkg::PH_VALUE;
                end else begin
                    o_state.sticky_error = rtd_pkg::ERR_NO_VALUE;
                end
            end else begin
                // a non-digit closes an open pair first
                if (in_value) begin
                    if (fin_big) begin
                        o_state.sticky_error = rtd_pkg::ERR_BIG_VALUE;
                    end else if (i_state.count_acc != '0) begin
                        if (fin_over) begin
                            o_state.sticky_error = rtd_pkg::ERR_OVERFLOW;
                        end else begin
                            o_run_valid          = 1'b1;
                            o_state.cells_placed = sum_placed[14:0];
                            o_state.placed_hi    = i_state.placed_hi | sum_placed[15];
                        end
                    end
                    o_state.count_acc = '0;
                    o_state.value_acc = '0;
                end
                o_state.phase = rtd_pkg::PH_BETWEEN;
                ge_total = o_state.placed_hi || (o_state.cells_placed >= total);
                if (o_state.sticky_error == rtd_pkg::ERR_OK && !is_space) begin
                    if (ge_total) begin
                        o_state.sticky_error = rtd_pkg::ERR_TRAILING;
                    end else if (is_digit) begin
                        o_state.count_acc = {11'd0, digit};
                        o_state.phase     = rtd_pkg::PH_COUNT;
                    end else begin
                        o_state.sticky_error = rtd_pkg::ERR_BAD_START;
                    end
                end
            end
        end

        // end of text: close what is open, check the fill, then clear
        if (i_word.is_final) begin
            if (o_state.sticky_error == rtd_pkg::ERR_OK) begin
                if (o_state.phase == rtd_pkg::PH_COUNT) begin
                    o_state.sticky_error = rtd_pkg::ERR_NO_COLON;
                end else if (o_state.phase == rtd_pkg::PH_COLON) begin
                    o_state.sticky_error = rtd_pkg::ERR_NO_VALUE;
                end else if (o_state.phase == rtd_pkg::PH_VALUE) begin
                    if (fin_big) begin
                        o_state.sticky_error = rtd_pkg::ERR_BIG_VALUE;
                    end else if (i_state.count_acc != '0) begin
                        if (fin_over) begin
                            o_state.sticky_error = rtd_pkg::ERR_OVERFLOW;
                        end else begin
                            o_run_valid          = 1'b1;
                            o_state.cells_placed = sum_placed[14:0];
                            o_state.placed_hi    = i_state.placed_hi | sum_placed[15];
                        end
                    end
                end
            end
            if (o_state.sticky_error == rtd_pkg::ERR_OK &&
                !(o_state.placed_hi || (o_state.cells_placed >= total))) begin
                o_state.sticky_error = rtd_pkg::ERR_SHORT;
            end
            o_done_valid           = 1'b1;
            o_done_word.error_code = o_state.sticky_error;
            o_state.phase          = rtd_pkg::PH_BETWEEN;
            o_state.count_acc      = '0;
            o_state.value_acc      = '0;
            o_state.cells_placed   = '0;
            o_state.placed_hi      = 1'b0;
            o_state.sticky_error   = rtd_pkg::ERR_OK;
        end
    end

endmodule

/* design/rtd_out_fifo.sv */
`timescale 1ns / 1ps
// result queue: takes up to two words per cycle, gives one per cycle while the reader is ready
// depends on rtd_pkg
module rtd_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_push_n,
    input  rtd_pkg::t_out_word   i_push0,
    input  rtd_pkg::t_out_word   i_push1,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rtd_pkg::t_out_word   o_word
);

    rtd_pkg::t_out_word               r_mem [rtd_pkg::FIFO_DEPTH];
    logic [rtd_pkg::FIFO_AW-1:0]      r_wr_ptr;
    logic [rtd_pkg::FIFO_AW-1:0]      n_wr_ptr;
    logic [rtd_pkg::FIFO_AW-1:0]      r_rd_ptr;
    logic [rtd_pkg::FIFO_AW-1:0]      n_rd_ptr;
    logic [rtd_pkg::FIFO_CW-1:0]      r_count;
    logic [rtd_pkg::FIFO_CW-1:0]      n_count;
    logic [rtd_pkg::FIFO_AW-1:0]      wr_ptr1;
    logic                             pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= rtd_pkg::FIFO_CW'(rtd_pkg::FIFO_DEPTH - 2));
    assign wr_ptr1 = r_wr_ptr + rtd_pkg::FIFO_AW'(1);

    // pointer and fill arithmetic
    always_comb begin
        n_wr_ptr = r_wr_ptr + rtd_pkg::FIFO_AW'(i_push_n);
        n_rd_ptr = pop ? r_rd_ptr + rtd_pkg::FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count + rtd_pkg::FIFO_CW'(i_push_n) - rtd_pkg::FIFO_CW'(pop);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_ptr1] <= i_push1;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rtd_pkg::FIFO_CW'(rtd_pkg::FIFO_DEPTH))
        else $error("result queue over capacity");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> (32'(r_count) + 32'(i_push_n) <= rtd_pkg::FIFO_DEPTH))
        else $error("push into full result queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n == 2'd0 && !pop) |=> $stable(r_count))
        else $error("queue count moved without push or pop");

endmodule

/* design/rle_text_run_decoder.sv */
`timescale 1ns / 1ps
// top level of the run-length text decoder: parse state, config register, result queue
// depends on rtd_pkg, rtd_step, rtd_out_fifo
//
// Takes one text character per cycle and gives a run word for each run placed by the
// character that closes its pair, followed on the final character by a done word with
// the error code. A character accepted at one edge updates the parse state and writes
// its words into the result queue at that edge, behind older words. A character can
// cause two words (a run and the done word); they sit in a four-word result queue,
// and o_in_ready is low only while that queue has fewer than two free slots, so input
// runs at one character per cycle whenever the output side keeps up. The grid size
// register is taken as min(i_cfg_wr_data, 16384) and should be written between texts.
module rle_text_run_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [14:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rtd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rtd_pkg::t_out_word o_out_word
);

    rtd_pkg::t_parse_state r_state;
    rtd_pkg::t_parse_state n_state;
    logic [14:0]           r_total_cells;
    logic                  in_acc;
    logic                  run_valid;
    logic                  done_valid;
    rtd_pkg::t_out_word    run_word;
    rtd_pkg::t_out_word    done_word;
    logic [1:0]            push_n;
    rtd_pkg::t_out_word    push0;

    assign in_acc = i_in_valid && o_in_ready;

    // per-character parse logic
    rtd_step u_step (
        .i_state       (r_state),
        .i_word        (i_in_word),
        .i_total_cells (r_total_cells),
        .o_state       (n_state),
        .o_run_valid   (run_valid),
        .o_run_word    (run_word),
        .o_done_valid  (done_valid),
        .o_done_word   (done_word)
    );

    // parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= rtd_pkg::PH_BETWEEN;
            r_state.count_acc    <= '0;
            r_state.value_acc    <= '0;
            r_state.cells_placed <= '0;
            r_state.placed_hi    <= 1'b0;
            r_state.sticky_error <= rtd_pkg::ERR_OK;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // grid size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_cells <= rtd_pkg::TOTAL_RESET;
        end else if (i_cfg_wr_en) begin
            r_total_cells <= i_cfg_wr_data;
        end
    end

    // queue the words of an accepted character, run word first
    always_comb begin
        push_n = '0;
        if (in_acc) begin
            push_n = {1'b0, run_valid} + {1'b0, done_valid};
        end
        push0 = run_valid ? run_word : done_word;
    end

    rtd_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_push0  (push0),
        .i_push1  (done_word),
        .o_room   (o_in_ready),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_word   (o_out_word)
    );

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.is_final) |=>
            (r_state.cells_placed == '0 && r_state.sticky_error == rtd_pkg::ERR_OK &&
             r_state.phase == rtd_pkg::PH_BETWEEN))
        else $error("parse state not cleared after final character");

    a_no_run_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.sticky_error != rtd_pkg::ERR_OK) |-> !run_valid)
        else $error("run word given after an error");

    a_done_only_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (done_valid == i_in_word.is_final))
        else $error("done word not tied to final character");

endmodule

/* tb/sv/rtd_run_checker.sv */
`timescale 1ns / 1ps
// word checker for the run-length text decoder: tracks the parse of each text,
// queues the expected run and done words and compares every accepted output word
// depends on rtd_pkg
module rtd_run_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [14:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  rtd_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  rtd_pkg::t_out_word i_out_word,
    output int                 o_pending,
    output int                 o_fail_count,
    output int                 o_word_count
);

    localparam int REPORT_MAX = 10;

    // mirrored parse state and grid setting
    rtd_pkg::t_phase    parse_phase;
    int unsigned        count_sum;
    int unsigned        value_sum;
    int unsigned        cells_done;
    int unsigned        grid_setting = rtd_pkg::TOTAL_RESET;
    rtd_pkg::t_err      text_error;
    rtd_pkg::t_out_word expected_words[$];
    int                 fails = 0;
    int                 checked = 0;

    function automatic bit is_digit_ch(logic [7:0] c);
        return (c >= rtd_pkg::CH_ZERO) && (c <= rtd_pkg::CH_NINE);
    endfunction

    function automatic bit is_blank_ch(logic [7:0] c);
        return (c == rtd_pkg::CH_SPACE) || ((c >= rtd_pkg::CH_TAB) && (c <= rtd_pkg::CH_CR));
    endfunction

    function automatic int unsigned grid_cells();
        return (grid_setting > rtd_pkg::MAX_CELLS) ? rtd_pkg::MAX_CELLS : grid_setting;
    endfunction

    // decimal digit shift with a ceiling
    function automatic int unsigned add_digit(int unsigned acc, logic [7:0] c,
                                              int unsigned ceiling);
        int unsigned v;
        v = acc * 10 + int'(c - rtd_pkg::CH_ZERO);
        return (v > ceiling) ? ceiling : v;
    endfunction

    function automatic void clear_text();
        parse_phase = rtd_pkg::PH_BETWEEN;
        count_sum   = 0;
        value_sum   = 0;
        cells_done  = 0;
        text_error  = rtd_pkg::ERR_OK;
    endfunction

    // a finished pair: either an error or a run word for a nonzero count
    function automatic void close_pair();
        rtd_pkg::t_out_word w;
        if (value_sum > rtd_pkg::VALUE_MAX) begin
            text_error = rtd_pkg::ERR_BIG_VALUE;
        end else if (count_sum > 0) begin
            if (count_sum > grid_cells() - cells_done) begin
                text_error = rtd_pkg::ERR_OVERFLOW;
            end else begin
                w             = '0;
                w.kind        = rtd_pkg::KIND_RUN;
                w.start_index = cells_done[13:0];
                w.run_length  = count_sum[14:0];
                w.cell_value  = value_sum[7:0];
                expected_words.insert(expected_words.size(), w);
                cells_done += count_sum;
            end
        end
        count_sum   = 0;
        value_sum   = 0;
        parse_phase = rtd_pkg::PH_BETWEEN;
    endfunction

    // one character of text
    function automatic void parse_char(logic [7:0] c);
        if (text_error != rtd_pkg::ERR_OK) return;
        if (parse_phase == rtd_pkg::PH_VALUE) begin
            if (is_digit_ch(c)) begin
                value_sum = add_digit(value_sum, c, rtd_pkg::VALUE_SAT);
                return;
            end
            close_pair();
            if (text_error != rtd_pkg::ERR_OK) return;
        end
        if (parse_phase == rtd_pkg::PH_COUNT) begin
            if (is_digit_ch(c)) count_sum = add_digit(count_sum, c, rtd_pkg::COUNT_SAT);
            else if (c == rtd_pkg::CH_COLON) parse_phase = rtd_pkg::PH_COLON;
            else text_error = rtd_pkg::ERR_NO_COLON;
            return;
        end
        if (parse_phase == rtd_pkg::PH_COLON) begin
            if (is_digit_ch(c)) begin
                value_sum   = int'(c - rtd_pkg::CH_ZERO);
                parse_phase = rtd_pkg::PH_VALUE;
            end else begin
                text_error = rtd_pkg::ERR_NO_VALUE;
            end
            return;
        end
        parse_phase = rtd_pkg::PH_BETWEEN;
        if (is_blank_ch(c)) return;
        if (cells_done >= grid_cells()) begin
            text_error = rtd_pkg::ERR_TRAILING;
            return;
        end
        if (is_digit_ch(c)) begin
            count_sum   = int'(c - rtd_pkg::CH_ZERO);
            parse_phase = rtd_pkg::PH_COUNT;
        end else begin
            text_error = rtd_pkg::ERR_BAD_START;
        end
    endfunction

    // end of text: settle an open pair, then the done word
    function automatic void end_text();
        rtd_pkg::t_out_word w;
        if (text_error == rtd_pkg::ERR_OK) begin
            if (parse_phase == rtd_pkg::PH_COUNT) text_error = rtd_pkg::ERR_NO_COLON;
            else if (parse_phase == rtd_pkg::PH_COLON) text_error = rtd_pkg::ERR_NO_VALUE;
            else if (parse_phase == rtd_pkg::PH_VALUE) close_pair();
        end
        if (text_error == rtd_pkg::ERR_OK && cells_done < grid_cells())
            text_error = rtd_pkg::ERR_SHORT;
        w            = '0;
        w.kind       = rtd_pkg::KIND_DONE;
        w.error_code = text_error;
        w.is_last    = 1'b1;
        expected_words.insert(expected_words.size(), w);
        clear_text();
    endfunction

    // compare one output word with the oldest expected word
    function automatic void check_word(rtd_pkg::t_out_word got);
        rtd_pkg::t_out_word exp_w;
        checked++;
        if (expected_words.size() == 0) begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("%0t: unexpected output word kind %0d start %0d len %0d %s %0d %0d %0d",
                         $realtime, got.kind, got.start_index, got.run_length,
                         "val/err/last", got.cell_value, got.error_code, got.is_last);
            return;
        end
        exp_w = expected_words.pop_front();
        if (got.kind !== exp_w.kind || got.start_index !== exp_w.start_index ||
            got.run_length !== exp_w.run_length || got.cell_value !== exp_w.cell_value ||
            got.error_code !== exp_w.error_code || got.is_last !== exp_w.is_last) begin
            fails++;
            if (fails <= REPORT_MAX) begin
                $display("%0t: word mismatch", $realtime);
                $display("  expected kind %0d start %0d len %0d val %0d err %0d last %0d",
                         exp_w.kind, exp_w.start_index, exp_w.run_length,
                         exp_w.cell_value, exp_w.error_code, exp_w.is_last);
                $display("  actual   kind %0d start %0d len %0d val %0d err %0d last %0d",
                         got.kind, got.start_index, got.run_length,
                         got.cell_value, got.error_code, got.is_last);
            end
        end
    endfunction

    // watch config writes and both channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid_setting = rtd_pkg::TOTAL_RESET;
            clear_text();
            expected_words.delete();
        end else begin
            if (i_cfg_wr_en) grid_setting = i_cfg_wr_data;
            if (i_out_valid && i_out_ready) check_word(i_out_word);
            if (i_in_valid && i_in_ready) begin
                parse_char(i_in_word.ch);
                if (i_in_word.is_final) end_text();
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fails;
        o_word_count <= checked;
    end

endmodule

/* tb/sv/tb_rle_text_run_decoder.sv */
`timescale 1ns / 1ps
// testbench top for the run-length text decoder: clock, reset, text stimulus,
// output stalls and the verdict; depends on rtd_pkg, rtd_run_checker, rle_text_run_decoder
module tb_rle_text_run_decoder;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_CHARS  = 220;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 7;
    localparam int QUIET_CYCLES = 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [14:0]        cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    rtd_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    rtd_pkg::t_out_word out_word;

    int          pending;
    int          fail_count;
    int          word_count;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_arm = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          texts_sent = 0;
    int          chars_sent = 0;
    logic [7:0]  text_bytes[$];

    rle_text_run_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_word    (in_word),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_word   (out_word)
    );

    rtd_run_checker run_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_word_count (word_count)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // output side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // offer one character and wait for it to be taken
    task automatic send_char(input logic [7:0] c, input logic fin);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid         <= 1'b1;
        in_word.ch       <= c;
        in_word.is_final <= fin;
        do @(posedge i_clk); while (!in_ready);
        chars_sent++;
    endtask

    // send the buffered text, final flag on its last character
    task automatic send_text();
        for (int k = 0; k < text_bytes.size(); k++)
            send_char(text_bytes[k], k == text_bytes.size() - 1);
        texts_sent++;
    endtask

    // append one character to the text buffer
    function automatic void put_byte(logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    task automatic send_string(input string s);
        text_bytes.delete();
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
        send_text();
    endtask

    // stop offering and let every expected word come out
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_grid(input logic [14:0] cells);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cells;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // decimal text of n with optional leading zeros
    function automatic void put_number(int unsigned n, int unsigned zeros);
        int unsigned div;
        div = 1;
        repeat (zeros) put_byte(rtd_pkg::CH_ZERO);
        while (div * 10 <= n) div *= 10;
        while (div > 0) begin
            put_byte(rtd_pkg::CH_ZERO + 8'((n / div) % 10));
            div /= 10;
        end
    endfunction

    function automatic void put_blank();
        int unsigned pick;
        pick = $urandom_range(5);
        put_byte((pick == 5) ? rtd_pkg::CH_SPACE : rtd_pkg::CH_TAB + 8'(pick));
    endfunction

    function automatic int unsigned lead_zeros();
        return ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0;
    endfunction

    function automatic void put_pair(int unsigned cnt, int unsigned val);
        put_number(cnt, lead_zeros());
        put_byte(rtd_pkg::CH_COLON);
        put_number(val, lead_zeros());
    endfunction

    function automatic int unsigned pick_value();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    // well-formed text that fills the grid, then maybe one defect
    function automatic void build_text(int unsigned grid);
        int unsigned left;
        int unsigned cnt;
        int unsigned npairs;
        int unsigned pos;
        left   = (grid > rtd_pkg::MAX_CELLS) ? rtd_pkg::MAX_CELLS : grid;
        npairs = 0;
        text_bytes.delete();
        if ($urandom_range(3) == 0) put_blank();
        while (left > 0) begin
            if (npairs == 5 || $urandom_range(2) == 0) cnt = left;
            else cnt = $urandom_range(1, left);
            if ($urandom_range(9) == 0) begin
                put_pair(0, pick_value());
                put_blank();
            end
            put_pair(cnt, pick_value());
            left -= cnt;
            npairs++;
            if (left > 0 || $urandom_range(1) == 0) begin
                put_blank();
                if ($urandom_range(3) == 0) put_blank();
            end
        end
        if ($urandom_range(2) == 0) begin
            pos = $urandom_range(text_bytes.size());
            case ($urandom_range(7))
                0: if (text_bytes.size() > 0)
                       text_bytes[$urandom_range(text_bytes.size() - 1)] = 8'($urandom_range(255));
                1: while (text_bytes.size() > pos && text_bytes.size() > 1)
                       text_bytes.delete(text_bytes.size() - 1);
                2: begin
                    put_blank();
                    put_pair($urandom_range(1, 3), pick_value());
                end
                3: begin
                    put_blank();
                    put_pair(1, $urandom_range(256, 99999));
                end
                4: begin
                    put_pair(99999, pick_value());
                    put_blank();
                end
                5: text_bytes.insert(pos, 8'($urandom_range(255)));
                6: if (text_bytes.size() > 0)
                       text_bytes.delete($urandom_range(text_bytes.size() - 1));
                default: begin
                    text_bytes.delete();
                    repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(255)));
                end
            endcase
        end
        if (text_bytes.size() == 0) put_blank();
    endfunction

    // stimulus and verdict
    initial begin
        int unsigned grid;
        int          phase_start;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed texts on a four-cell grid
        tx_idle_pct = 21;
        rx_idle_pct = 53;
        write_grid(15'd4);
        send_string("0:9 4:255");
        text_bytes.delete();
        put_byte(8'hFF);
        send_text();
        send_string("3");
        send_string("3:");
        send_string("5:1");
        send_string("1:1");
        send_string("4:1 z");
        send_string("1:256");
        wait_quiet();

        // random texts over several grid sizes and idle patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       grid = 1;
                2:       grid = rtd_pkg::MAX_CELLS;
                3:       grid = 32767;
                4:       grid = 0;
                6:       grid = $urandom_range(41, rtd_pkg::MAX_CELLS - 1);
                default: grid = $urandom_range(2, 40);
            endcase
            tx_idle_pct = (p < 2) ? 21 : (p < 4) ? 53 : 0;
            rx_idle_pct = (p < 2) ? 53 : (p < 4) ? 21 : 0;
            write_grid(15'(grid));
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                build_text(grid);
                send_text();
                // long output stall once the second idle-free phase is under way
                if (p == 5 && chars_sent - phase_start > 40) hold_arm = 1'b1;
            end
            wait_quiet();
        end

        $display("covered %0d texts, %0d characters and %0d checked words",
                 texts_sent, chars_sent, word_count);
        $display("grids of 0, 1, 4, 16384 and a clamped 32767 plus random sizes, "
                 , "three idle patterns and a %0d-cycle output stall", HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d failing words", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
